/* rtl/core/bpp_pkg.sv */
// shared types, constants and saturation helpers for the particle push unit
package bpp_pkg;

    localparam int DW        = 32;   // q16.16 word
    localparam int WIDE_W    = 66;   // headroom for products plus sums
    localparam int UOP_W     = 5;
    localparam int DIV_STEPS = 33;   // quotient bits kept by the divider
    localparam int DCNT_W    = 6;
    localparam int DEN_W     = 49;   // 2^16 + tt/2^16 fits here

    // micro-op slots on the shared multiplier
    localparam logic [UOP_W-1:0] UOP_H    = 5'd0;
    localparam logic [UOP_W-1:0] UOP_A0   = 5'd1;
    localparam logic [UOP_W-1:0] UOP_T0   = 5'd4;
    localparam logic [UOP_W-1:0] UOP_TT0  = 5'd7;
    localparam logic [UOP_W-1:0] UOP_TT2  = 5'd9;
    localparam logic [UOP_W-1:0] UOP_VP0  = 5'd10;
    localparam logic [UOP_W-1:0] UOP_NV0  = 5'd16;
    localparam logic [UOP_W-1:0] UOP_POS0 = 5'd22;
    localparam logic [UOP_W-1:0] UOP_LAST = 5'd24;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_DINIT, ST_DIV, ST_DFIN, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        GRP_H, GRP_A, GRP_T, GRP_TT, GRP_VP, GRP_NV, GRP_POS
    } grp_t;

    typedef enum logic [3:0] {
        REG_QM  = 4'd0,
        REG_DT  = 4'd1,
        REG_SPX = 4'd2,
        REG_SPY = 4'd3,
        REG_SPZ = 4'd4,
        REG_SVX = 4'd5,
        REG_SVY = 4'd6,
        REG_SVZ = 4'd7
    } reg_idx_t;

    function automatic logic signed [WIDE_W-1:0] ext32(input logic signed [DW-1:0] x);
        return {{(WIDE_W-DW){x[DW-1]}}, x};
    endfunction

    function automatic logic signed [WIDE_W-1:0] ext64(input logic signed [63:0] x);
        return {{(WIDE_W-64){x[63]}}, x};
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x[WIDE_W-1:DW-1] == '0 || x[WIDE_W-1:DW-1] == '1) begin
            return x[DW-1:0];
        end
        return x[WIDE_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

endpackage

/* rtl/core/boris_particle_push_unit.sv */
// boris particle push unit: one boris step per item on a shared multiplier and divider
module boris_particle_push_unit
    import bpp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // e_x, e_y, e_z, b_x, b_y, b_z
    input  logic         s_tuser,   // restart
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
);

    // Each accepted item runs through 25 multiplier slots, each a multiply
    // step and then an accumulate and saturate step, and three passes of the
    // restoring divider for s = 2t/(1+t.t), then hands off to the output
    // register. s_tready is high only while the sequencer is idle, so a new
    // item is taken only once the previous step is done; the step length is
    // set by the 33 quotient steps per divider pass and by the single 32x32
    // multiplier. A finished result waits in its own output register, so the
    // next item may be accepted before the result is taken.
    // Restart (tuser) reloads position and velocity from the start registers
    // before the step. All values are signed q16.16 and saturate.

    // configuration registers
    logic signed [31:0] qm_reg;
    logic [30:0]        dt_reg;
    logic signed [31:0] spos_reg [3];
    logic signed [31:0] svel_reg [3];

    // particle state and working values
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] e_reg   [3];
    logic signed [31:0] b_reg   [3];
    logic signed [31:0] a_reg   [3];
    logic signed [31:0] t_reg   [3];
    logic signed [31:0] s_reg   [3];
    logic signed [31:0] vp_reg  [3];
    logic signed [31:0] h_reg;
    logic [63:0]        tt_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [63:0] prod_reg;

    // sequencer
    state_t             state_reg, state_next;
    logic [UOP_W-1:0]   uop_reg;
    logic [1:0]         div_idx_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;

    // divider
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_STEPS-1:0] num_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic                 neg_reg;

    // output register
    logic         m_valid_reg;
    logic [191:0] m_data_reg;

    logic in_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    function automatic logic [1:0] nxt(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    // micro-op decode: group, lane and phase of the current slot
    grp_t             grp;
    logic [UOP_W-1:0] off;
    logic [1:0]       lane, lj, lk;
    logic             phase;

    always_comb begin
        case (uop_reg) inside
            [UOP_A0:UOP_A0+2]:     begin grp = GRP_A;  off = uop_reg - UOP_A0;   end
            [UOP_T0:UOP_T0+2]:     begin grp = GRP_T;  off = uop_reg - UOP_T0;   end
            [UOP_TT0:UOP_TT2]:     begin grp = GRP_TT; off = uop_reg - UOP_TT0;  end
            [UOP_VP0:UOP_VP0+5]:   begin grp = GRP_VP; off = uop_reg - UOP_VP0;  end
            [UOP_NV0:UOP_NV0+5]:   begin grp = GRP_NV; off = uop_reg - UOP_NV0;  end
            [UOP_POS0:UOP_LAST]:   begin grp = GRP_POS; off = uop_reg - UOP_POS0; end
            default:               begin grp = GRP_H;  off = '0;                 end
        endcase
        // cross product slots come in pairs per lane
        if (grp == GRP_VP || grp == GRP_NV) begin
            lane  = off[2:1];
            phase = off[0];
        end else begin
            lane  = off[1:0];
            phase = 1'b0;
        end
        lj = nxt(lane);
        lk = nxt(lj);
    end

    // operand select for the shared multiplier
    logic signed [31:0] op_a, op_b;

    always_comb begin
        unique case (grp)
            GRP_H:   begin op_a = qm_reg;        op_b = {1'b0, dt_reg}; end
            GRP_A:   begin op_a = e_reg[lane];   op_b = h_reg;          end
            GRP_T:   begin op_a = b_reg[lane];   op_b = h_reg;          end
            GRP_TT:  begin op_a = t_reg[lane];   op_b = t_reg[lane];    end
            GRP_VP:  begin
                op_a = phase ? vel_reg[lk] : vel_reg[lj];
                op_b = phase ? t_reg[lj]   : t_reg[lk];
            end
            GRP_NV:  begin
                op_a = phase ? vp_reg[lk] : vp_reg[lj];
                op_b = phase ? s_reg[lj]  : s_reg[lk];
            end
            GRP_POS: begin op_a = vel_reg[lane]; op_b = {1'b0, dt_reg}; end
            default: begin op_a = '0;            op_b = '0;             end
        endcase
    end

    // floor(product / 2^16), widened
    logic signed [WIDE_W-1:0] pf;
    logic signed [63:0]       prod_fl;
    assign prod_fl = prod_reg >>> 16;
    assign pf      = ext64(prod_fl);

    // divider trial subtract
    logic [DEN_W+1:0] div_diff;
    assign div_diff = {1'b0, rem_reg, num_reg[DIV_STEPS-1]} - {2'b0, den_reg};

    // divider setup from the selected t component
    logic signed [31:0] t_sel;
    logic [31:0]        t_mag;
    assign t_sel = t_reg[div_idx_reg];
    assign t_mag = t_sel[31] ? 32'(-t_sel) : 32'(t_sel);

    logic signed [WIDE_W-1:0] quo_w;
    assign quo_w = {{(WIDE_W-DIV_STEPS){1'b0}}, quo_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC: begin
                if (uop_reg == UOP_TT2) begin
                    state_next = ST_DINIT;
                end else if (uop_reg == UOP_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:   if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) state_next = ST_DFIN;
            ST_DFIN:  state_next = (div_idx_reg == 2'd2) ? ST_MUL : ST_DINIT;
            ST_DONE:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control, configuration and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            qm_reg      <= 32'sd65536;
            dt_reg      <= 31'd655;
            uop_reg     <= '0;
            div_idx_reg <= '0;
            div_cnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                spos_reg[i] <= '0;
                svel_reg[i] <= '0;
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_addr))
                    REG_QM:  qm_reg      <= cfg_wdata;
                    REG_DT:  dt_reg      <= cfg_wdata[30:0];
                    REG_SPX: spos_reg[0] <= cfg_wdata;
                    REG_SPY: spos_reg[1] <= cfg_wdata;
                    REG_SPZ: spos_reg[2] <= cfg_wdata;
                    REG_SVX: svel_reg[0] <= cfg_wdata;
                    REG_SVY: svel_reg[1] <= cfg_wdata;
                    REG_SVZ: svel_reg[2] <= cfg_wdata;
                    default: ;   // indexes past the list are dropped
                endcase
            end

            // output handshake
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        uop_reg     <= UOP_H;
                        div_idx_reg <= '0;
                        if (s_tuser) begin
                            for (int i = 0; i < 3; i++) begin
                                pos_reg[i] <= spos_reg[i];
                                vel_reg[i] <= svel_reg[i];
                            end
                        end
                    end
                end
                ST_ACC: begin
                    uop_reg <= uop_reg + 1'b1;
                    case (grp)
                        // first half kick folded into velocity
                        GRP_A:   vel_reg[lane] <= sat32(ext32(vel_reg[lane]) +
                                                        ext32(sat32(pf)));
                        GRP_NV:  if (phase) begin
                            vel_reg[lane] <= sat32(ext32(sat32(acc_reg - pf)) +
                                                   ext32(a_reg[lane]));
                        end
                        GRP_POS: pos_reg[lane] <= sat32(ext32(pos_reg[lane]) + pf);
                        default: ;
                    endcase
                end
                ST_DINIT: div_cnt_reg <= '0;
                ST_DIV:   div_cnt_reg <= div_cnt_reg + 1'b1;
                ST_DFIN:  div_idx_reg <= div_idx_reg + 1'b1;
                default:  ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
                e_reg[i] <= s_tdata[32*i +: 32];
                b_reg[i] <= s_tdata[96 + 32*i +: 32];
            end
        end

        if (state_reg == ST_MUL) begin
            prod_reg <= op_a * op_b;
        end

        if (state_reg == ST_ACC) begin
            case (grp)
                GRP_H:  h_reg <= sat32(ext64(prod_reg) >>> 17);
                GRP_A:  a_reg[lane] <= sat32(pf);
                GRP_T:  t_reg[lane] <= sat32(pf);
                GRP_TT: tt_reg <= (lane == 2'd0) ? prod_reg : tt_reg + prod_reg;
                GRP_VP: begin
                    if (phase) vp_reg[lane] <= sat32(acc_reg - pf);
                    else       acc_reg      <= ext32(vel_reg[lane]) + pf;
                end
                GRP_NV: if (!phase) acc_reg <= ext32(vel_reg[lane]) + pf;
                default: ;
            endcase
        end

        // first 16 numerator bits never reach the denominator: start past them
        if (state_reg == ST_DINIT) begin
            rem_reg <= {{(DEN_W-16){1'b0}}, t_mag[31:16]};
            num_reg <= {t_mag[15:0], 17'b0};
            quo_reg <= '0;
            neg_reg <= t_sel[31];
            den_reg <= DEN_W'(65536) + {1'b0, tt_reg[63:16]};
        end

        if (state_reg == ST_DIV) begin
            num_reg <= {num_reg[DIV_STEPS-2:0], 1'b0};
            if (!div_diff[DEN_W+1]) begin
                rem_reg <= div_diff[DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DEN_W-2:0], num_reg[DIV_STEPS-1]};
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b0};
            end
        end

        // quotient truncates toward zero: sign goes on the magnitude
        if (state_reg == ST_DFIN) begin
            s_reg[div_idx_reg] <= neg_reg ? sat32(-quo_w) : sat32(quo_w);
        end

        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            for (int i = 0; i < 3; i++) begin
                m_data_reg[32*i +: 32]      <= pos_reg[i];
                m_data_reg[96 + 32*i +: 32] <= vel_reg[i];
            end
        end
    end

endmodule

/* rtl/core/bpp_checker.sv */
// port-level checks for the particle push unit, bound to the top level
module bpp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    // a waiting result holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the sequencer goes busy right after taking an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after accept");

    // an item does not finish early: ready is still low later after its accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##3 !s_tready)
        else $error("item finished too early");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind boris_particle_push_unit bpp_checker u_bpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
